@@ rtl/core/complex_fir_filter_defines.svh @@
// assertion macros for the complex fir filter
`ifndef COMPLEX_FIR_FILTER_DEFINES_SVH
`define COMPLEX_FIR_FILTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CFIR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfir: same-cycle check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define CFIR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cfir: next-cycle check failed");

`endif

@@ rtl/core/cfir_pkg.sv @@
// shared constants and types for the complex fir filter
package cfir_pkg;

	localparam int MAX_TAPS_DEF = 64;
	localparam int DATA_W       = 16;
	localparam int PROD_W       = 32;
	localparam int ACC_W        = 38;
	localparam int TAP_CNT_W    = 7;
	localparam int TAP_IDX_W    = 6;
	localparam int APB_ADDR_W   = 3;
	localparam int APB_DATA_W   = 32;
	localparam int REG_IDX_W    = 1;

	localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 7'd64;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT = 1'b0;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	// controls broadcast to every cell of the ring
	typedef struct packed {
		logic                 win_en;
		logic                 coef_shift;
		logic                 coef_load;
		logic [TAP_IDX_W-1:0] load_idx;
	} ctl_t;

endpackage

@@ rtl/core/cfir_cell.sv @@
// one ring cell: a delay line sample pair and one coefficient
module cfir_cell #(
	parameter int CELL_INDEX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfir_pkg::ctl_t       ctl,
	input  cfir_pkg::data_t      win_re_in,
	input  cfir_pkg::data_t      win_im_in,
	input  cfir_pkg::data_t      coef_in,
	input  cfir_pkg::data_t      load_value,
	output cfir_pkg::data_t      win_re,
	output cfir_pkg::data_t      win_im,
	output cfir_pkg::data_t      coef
);

	cfir_pkg::data_t win_re_q;
	cfir_pkg::data_t win_im_q;
	cfir_pkg::data_t coef_q;
	logic            hit;

	assign hit = ctl.coef_load && (32'(ctl.load_idx) == 32'(CELL_INDEX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_re_q <= '0;
			win_im_q <= '0;
			coef_q   <= '0;
		end else begin
			if (ctl.win_en) begin
				win_re_q <= win_re_in;
				win_im_q <= win_im_in;
			end
			if (hit) begin
				coef_q <= load_value;
			end else if (ctl.coef_shift) begin
				coef_q <= coef_in;
			end
		end
	end

	assign win_re = win_re_q;
	assign win_im = win_im_q;
	assign coef   = coef_q;

endmodule

@@ rtl/core/cfir_mac.sv @@
// multiply-accumulate at the head of the ring, product registered before the add
module cfir_mac (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clear,
	input  logic             en,
	input  cfir_pkg::data_t  coef,
	input  cfir_pkg::data_t  win_re,
	input  cfir_pkg::data_t  win_im,
	output cfir_pkg::acc_t   acc_re,
	output cfir_pkg::acc_t   acc_im
);

	logic signed [cfir_pkg::PROD_W-1:0] prod_re;
	logic signed [cfir_pkg::PROD_W-1:0] prod_im;
	logic signed [cfir_pkg::PROD_W-1:0] prod_re_s1;
	logic signed [cfir_pkg::PROD_W-1:0] prod_im_s1;
	logic                               en_s1;
	cfir_pkg::acc_t                     acc_re_q;
	cfir_pkg::acc_t                     acc_im_q;

	assign prod_re = cfir_pkg::PROD_W'(coef) * cfir_pkg::PROD_W'(win_re);
	assign prod_im = cfir_pkg::PROD_W'(coef) * cfir_pkg::PROD_W'(win_im);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= en && !clear;
		end
	end

	always_ff @(posedge clk) begin
		prod_re_s1 <= prod_re;
		prod_im_s1 <= prod_im;
		if (clear) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (en_s1) begin
			// wraps modulo 2^38
			acc_re_q <= acc_re_q + cfir_pkg::ACC_W'(prod_re_s1);
			acc_im_q <= acc_im_q + cfir_pkg::ACC_W'(prod_im_s1);
		end
	end

	assign acc_re = acc_re_q;
	assign acc_im = acc_im_q;

endmodule

@@ rtl/core/complex_fir_filter.sv @@
// complex fir filter top: apb tap count register, cell ring and head mac
//
//  channel   direction  handshake            payload
//  config    in/out     psel penable pready  paddr pwdata prdata (tap_count)
//  input     in         in_valid in_stall    op sample_re sample_im tap_index tap_value
//  output    out        out_valid out_stall  result_re result_im
//
// a load transaction leaves the input free for the next one; a sample transaction
// runs until the two rings of MAX_TAPS cells have rotated past the single mac
// (window ring full turn, coefficient ring offset set by T, the clamped tap count).
// reset clears the delay line and coefficients to zero and tap_count to 64.
// in_stall is high while a sample is worked on or its result waits for a free
// output register; the output register holds a result while out_stall is high.
module complex_fir_filter #(
	parameter int MAX_TAPS = cfir_pkg::MAX_TAPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cfir_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [cfir_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [cfir_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  cfir_pkg::data_t                     sample_re,
	input  cfir_pkg::data_t                     sample_im,
	input  logic [cfir_pkg::TAP_IDX_W-1:0]      tap_index,
	input  cfir_pkg::data_t                     tap_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output cfir_pkg::acc_t                      result_re,
	output cfir_pkg::acc_t                      result_im
);

	`include "complex_fir_filter_defines.svh"

	localparam int CNT_W = $clog2(2 * MAX_TAPS);
	localparam int EXT_W = ((cfir_pkg::TAP_CNT_W > CNT_W) ? cfir_pkg::TAP_CNT_W : CNT_W) + 1;
	localparam logic [CNT_W-1:0] M_CNT = CNT_W'(MAX_TAPS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]                        state_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic [CNT_W-1:0]                  d_q;
	logic [cfir_pkg::TAP_CNT_W-1:0]    tap_count_q;
	logic                              out_valid_q;
	cfir_pkg::acc_t                    result_re_q;
	cfir_pkg::acc_t                    result_im_q;

	logic                              cfg_wr;
	logic [cfir_pkg::REG_IDX_W-1:0]    reg_idx;
	logic                              in_accept;
	logic                              smp_acc;
	logic                              load_acc;
	logic                              run_last;
	logic                              mac_en;
	logic                              out_free;
	logic [EXT_W-1:0]                  taps_raw;
	logic [EXT_W-1:0]                  taps_clamp;
	logic [EXT_W-1:0]                  d_next;
	cfir_pkg::ctl_t                    ctl;
	cfir_pkg::data_t                   head_re;
	cfir_pkg::data_t                   head_im;
	cfir_pkg::acc_t                    acc_re;
	cfir_pkg::acc_t                    acc_im;

	cfir_pkg::data_t win_re_w [MAX_TAPS];
	cfir_pkg::data_t win_im_w [MAX_TAPS];
	cfir_pkg::data_t coef_w   [MAX_TAPS];

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[cfir_pkg::APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			cfir_pkg::REG_TAP_COUNT: prdata = cfir_pkg::APB_DATA_W'(tap_count_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= cfir_pkg::TAP_COUNT_RST;
		end else if (cfg_wr && reg_idx == cfir_pkg::REG_TAP_COUNT) begin
			tap_count_q <= pwdata[cfir_pkg::TAP_CNT_W-1:0];
		end
	end

	// handshake
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign smp_acc   = in_accept && (op == cfir_pkg::OP_SAMPLE);
	assign load_acc  = in_accept && (op == cfir_pkg::OP_LOAD);
	assign out_free  = !out_valid_q || !out_stall;

	// coefficient ring starts late by d so tap 0 meets window age T-1
	always_comb begin
		taps_raw   = EXT_W'(tap_count_q);
		taps_clamp = taps_raw;
		if (taps_raw == '0) begin
			taps_clamp = EXT_W'(1);
		end else if (taps_raw > EXT_W'(MAX_TAPS)) begin
			taps_clamp = EXT_W'(MAX_TAPS);
		end
		d_next = EXT_W'(MAX_TAPS) - taps_clamp + EXT_W'(1);
	end

	assign run_last = (cnt_q == d_q + CNT_W'(MAX_TAPS - 1));
	assign mac_en   = (state_q == ST_RUN) && (cnt_q >= d_q) && (cnt_q <= M_CNT);

	always_comb begin
		ctl.win_en     = smp_acc || ((state_q == ST_RUN) && (cnt_q < M_CNT));
		ctl.coef_shift = (state_q == ST_RUN) && (cnt_q >= d_q);
		ctl.coef_load  = load_acc;
		ctl.load_idx   = tap_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			d_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (smp_acc) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
						d_q     <= CNT_W'(d_next);
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (run_last) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			result_re_q <= acc_re;
			result_im_q <= acc_im;
		end
	end

	assign out_valid = out_valid_q;
	assign result_re = result_re_q;
	assign result_im = result_im_q;

	// new sample enters cell 0, otherwise the window ring closes on itself
	assign head_re = smp_acc ? sample_re : win_re_w[MAX_TAPS-1];
	assign head_im = smp_acc ? sample_im : win_im_w[MAX_TAPS-1];

	for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
		if (g == 0) begin : g_head
			cfir_cell #(
				.CELL_INDEX (g)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.win_re_in  (head_re),
				.win_im_in  (head_im),
				.coef_in    (coef_w[(g + 1) % MAX_TAPS]),
				.load_value (tap_value),
				.win_re     (win_re_w[g]),
				.win_im     (win_im_w[g]),
				.coef       (coef_w[g])
			);
		end else begin : g_body
			cfir_cell #(
				.CELL_INDEX (g)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.win_re_in  (win_re_w[g-1]),
				.win_im_in  (win_im_w[g-1]),
				.coef_in    (coef_w[(g + 1) % MAX_TAPS]),
				.load_value (tap_value),
				.win_re     (win_re_w[g]),
				.win_im     (win_im_w[g]),
				.coef       (coef_w[g])
			);
		end
	end

	cfir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (smp_acc),
		.en     (mac_en),
		.coef   (coef_w[0]),
		.win_re (win_re_w[0]),
		.win_im (win_im_w[0]),
		.acc_re (acc_re),
		.acc_im (acc_im)
	);

	`CFIR_ASSERT_NXT(a_sample_starts_run, smp_acc, state_q == ST_RUN && cnt_q == '0)
	`CFIR_ASSERT_IMP(a_offset_in_range, state_q == ST_RUN, d_q >= CNT_W'(1) && d_q <= M_CNT)
	`CFIR_ASSERT_IMP(a_flush_after_run, state_q == ST_FLUSH, !mac_en && $past(state_q) == ST_RUN)

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the complex fir filter: directed table, then random phases
module tb;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 2 * cfir_pkg::MAX_TAPS_DEF + 8;
	localparam int PRINT_CAP    = 40;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 73;
	localparam int PHASE_LOADS  = 8;
	localparam int NT           = cfir_pkg::MAX_TAPS_DEF;
	localparam int IDX_W        = cfir_pkg::TAP_IDX_W;
	localparam int CNT_W        = cfir_pkg::TAP_CNT_W;
	localparam int A_W          = cfir_pkg::APB_ADDR_W;
	localparam int D_W          = cfir_pkg::APB_DATA_W;

	typedef struct packed {
		cfir_pkg::acc_t re;
		cfir_pkg::acc_t im;
	} cplx_acc_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic                   op;
		cfir_pkg::data_t        re;
		cfir_pkg::data_t        im;
		logic [IDX_W-1:0]       idx;
		cfir_pkg::data_t        val;
		logic [CNT_W-1:0]       cfg;
		logic                   has_want;
		cplx_acc_t              want;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [A_W-1:0]         paddr;
	logic [D_W-1:0]         pwdata;
	logic [D_W-1:0]         prdata;
	logic                   pready;
	logic                   in_valid;
	logic                   in_stall;
	logic                   op;
	cfir_pkg::data_t        sample_re;
	cfir_pkg::data_t        sample_im;
	logic [IDX_W-1:0]       tap_index;
	cfir_pkg::data_t        tap_value;
	logic                   out_valid;
	logic                   out_stall;
	cfir_pkg::acc_t         result_re;
	cfir_pkg::acc_t         result_im;

	// predictor state
	cfir_pkg::data_t        delay_re [NT];
	cfir_pkg::data_t        delay_im [NT];
	cfir_pkg::data_t        coef_mem [NT];
	logic [CNT_W-1:0]       tap_cnt_reg;

	cplx_acc_t              pending_sums [$];
	stim_row_t              dir_rows [$];

	int                     send_idle_pct;
	int                     stall_pct;
	int                     mismatches;
	int                     n_samples;
	int                     n_loads;
	int                     n_results;
	int                     n_settings;
	int                     cycle_cnt;

	complex_fir_filter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.sample_re (sample_re),
		.sample_im (sample_im),
		.tap_index (tap_index),
		.tap_value (tap_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_re (result_re),
		.result_im (result_im)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results pending", cycle_cnt,
					pending_sums.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got,
				want);
	endtask

	// output transaction is decided by the values held between edges
	initial begin
		cplx_acc_t want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				n_results++;
				if (pending_sums.size() == 0) begin
					report_mismatch("result with nothing pending, result_re",
						longint'(result_re), 0);
				end else begin
					want = pending_sums.pop_front();
					if (result_re !== want.re)
						report_mismatch("result_re", longint'(result_re), longint'(want.re));
					if (result_im !== want.im)
						report_mismatch("result_im", longint'(result_im), longint'(want.im));
				end
			end
		end
	end

	// shift the delay line and form the complex dot product with the taps in use
	function automatic cplx_acc_t filter_sample(input cfir_pkg::data_t re,
			input cfir_pkg::data_t im);
		int        taps;
		longint    acc_re;
		longint    acc_im;
		cplx_acc_t r;
		for (int k = NT - 1; k > 0; k--) begin
			delay_re[k] = delay_re[k-1];
			delay_im[k] = delay_im[k-1];
		end
		delay_re[0] = re;
		delay_im[0] = im;
		taps = int'(tap_cnt_reg);
		if (taps == 0)
			taps = 1;
		if (taps > NT)
			taps = NT;
		acc_re = 0;
		acc_im = 0;
		// oldest sample in the window meets tap 0
		for (int j = 0; j < taps; j++) begin
			acc_re += longint'(coef_mem[j]) * longint'(delay_re[taps-1-j]);
			acc_im += longint'(coef_mem[j]) * longint'(delay_im[taps-1-j]);
		end
		r.re = cfir_pkg::acc_t'(acc_re);
		r.im = cfir_pkg::acc_t'(acc_im);
		return r;
	endfunction

	function automatic int active_taps();
		int t;
		t = int'(tap_cnt_reg);
		if (t == 0)
			t = 1;
		if (t > NT)
			t = NT;
		return t;
	endfunction

	function automatic cfir_pkg::data_t pick_q15();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return cfir_pkg::data_t'($urandom_range(2)) - 16'sd1;
			default: return cfir_pkg::data_t'($urandom);
		endcase
	endfunction

	function automatic stim_row_t mk_item(input logic o, input cfir_pkg::data_t re,
			input cfir_pkg::data_t im, input logic [IDX_W-1:0] idx,
			input cfir_pkg::data_t val, input logic has_want,
			input cfir_pkg::acc_t want_re, input cfir_pkg::acc_t want_im);
		stim_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.op = o;
		r.re = re;
		r.im = im;
		r.idx = idx;
		r.val = val;
		r.has_want = has_want;
		r.want.re = want_re;
		r.want.im = want_im;
		return r;
	endfunction

	function automatic stim_row_t mk_cfg(input logic [CNT_W-1:0] taps);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.cfg = taps;
		return r;
	endfunction

	task automatic add_row(input stim_row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endtask

	task automatic send_item(input logic o, input cfir_pkg::data_t re,
			input cfir_pkg::data_t im, input logic [IDX_W-1:0] idx,
			input cfir_pkg::data_t val, input logic use_typed, input cplx_acc_t typed);
		cplx_acc_t got;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		sample_re <= re;
		sample_im <= im;
		tap_index <= idx;
		tap_value <= val;
		forever begin
			@(negedge clk);
			if (!in_stall)
				break;
			@(posedge clk);
		end
		// transaction taken at the coming edge
		if (o == cfir_pkg::OP_LOAD) begin
			coef_mem[idx] = val;
			n_loads++;
		end else begin
			got = filter_sample(re, im);
			pending_sums.insert(pending_sums.size(), use_typed ? typed : got);
			n_samples++;
		end
		@(posedge clk);
	endtask

	task automatic send_random(input logic o, input logic [IDX_W-1:0] idx);
		cfir_pkg::data_t re;
		cfir_pkg::data_t im;
		cfir_pkg::data_t val;
		re = pick_q15();
		im = pick_q15();
		val = pick_q15();
		send_item(o, re, im, idx, val, 1'b0, '0);
	endtask

	// let every result drain and any sample in flight finish before a register write
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tap_count(input logic [CNT_W-1:0] taps);
		logic [D_W-1:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {cfir_pkg::REG_TAP_COUNT, 2'b00};
		pwdata  <= D_W'(taps);
		@(posedge clk);
		penable <= 1'b1;
		forever begin
			@(negedge clk);
			if (pready)
				break;
			@(posedge clk);
		end
		@(posedge clk);
		tap_cnt_reg = taps;
		n_settings++;
		// read back the same register
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		forever begin
			@(negedge clk);
			if (pready)
				break;
			@(posedge clk);
		end
		rd = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd[CNT_W-1:0] !== taps)
			report_mismatch("tap_count readback", longint'(rd[CNT_W-1:0]), longint'(taps));
	endtask

	initial begin
		int taps;
		int lim;
		logic o;

		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		op            = cfir_pkg::OP_SAMPLE;
		sample_re     = '0;
		sample_im     = '0;
		tap_index     = '0;
		tap_value     = '0;
		send_idle_pct = 0;
		stall_pct     = 0;
		mismatches    = 0;
		n_samples     = 0;
		n_loads       = 0;
		n_results     = 0;
		n_settings    = 0;
		tap_cnt_reg   = cfir_pkg::TAP_COUNT_RST;
		for (int k = 0; k < NT; k++) begin
			delay_re[k] = '0;
			delay_im[k] = '0;
			coef_mem[k] = '0;
		end

		// directed rows: reset state, extreme products, tap count clamping
		add_row(mk_item(cfir_pkg::OP_SAMPLE, 16'sh7FFF, 16'sh8000, 6'h3F, 16'sh7FFF, 1'b1,
			38'sd0, 38'sd0));
		add_row(mk_item(cfir_pkg::OP_SAMPLE, 16'sh8000, 16'sh7FFF, 6'h3F, 16'shFFFF, 1'b1,
			38'sd0, 38'sd0));
		add_row(mk_item(cfir_pkg::OP_LOAD, 16'sh7FFF, 16'sh7FFF, 6'h3F, 16'sh8000, 1'b0,
			'0, '0));
		add_row(mk_item(cfir_pkg::OP_SAMPLE, 16'sh8000, 16'sh8000, 6'h00, 16'sh0000, 1'b1,
			38'sd1073741824, 38'sd1073741824));
		add_row(mk_item(cfir_pkg::OP_SAMPLE, 16'sh7FFF, 16'sh8000, 6'h15, 16'sh5555, 1'b1,
			-38'sd1073709056, 38'sd1073741824));
		add_row(mk_item(cfir_pkg::OP_LOAD, 16'sh8000, 16'shFFFF, 6'h00, 16'sh7FFF, 1'b0,
			'0, '0));
		add_row(mk_item(cfir_pkg::OP_SAMPLE, 16'sh0000, 16'sh0000, 6'h2A, 16'sh8000, 1'b1,
			38'sd0, 38'sd0));
		// zero acts as one tap
		add_row(mk_cfg(7'd0));
		add_row(mk_item(cfir_pkg::OP_SAMPLE, 16'sh8000, 16'sh7FFF, 6'h3F, 16'shFFFF, 1'b1,
			-38'sd1073709056, 38'sd1073676289));
		add_row(mk_cfg(7'd1));
		add_row(mk_item(cfir_pkg::OP_SAMPLE, 16'sh0001, 16'shFFFF, 6'h00, 16'sh0000, 1'b1,
			38'sd32767, -38'sd32767));
		// above the maximum acts as the maximum
		add_row(mk_cfg(7'd127));
		add_row(mk_item(cfir_pkg::OP_SAMPLE, 16'sh7FFF, 16'sh7FFF, 6'h2A, 16'sh2AAA, 1'b0,
			'0, '0));
		add_row(mk_cfg(7'd2));
		add_row(mk_item(cfir_pkg::OP_LOAD, 16'sh5555, 16'sh2AAA, 6'h01, 16'shFFFF, 1'b0,
			'0, '0));
		add_row(mk_item(cfir_pkg::OP_SAMPLE, 16'sh8000, 16'sh0000, 6'h15, 16'sh7FFF, 1'b0,
			'0, '0));
		add_row(mk_item(cfir_pkg::OP_LOAD, 16'sh0000, 16'sh0000, 6'h2A, 16'sh8000, 1'b0,
			'0, '0));
		add_row(mk_item(cfir_pkg::OP_LOAD, 16'shFFFF, 16'sh8000, 6'h15, 16'sh5A5A, 1'b0,
			'0, '0));
		add_row(mk_cfg(7'd64));
		add_row(mk_item(cfir_pkg::OP_SAMPLE, 16'sh1234, 16'shEDCB, 6'h3F, 16'sh8000, 1'b0,
			'0, '0));
		add_row(mk_item(cfir_pkg::OP_SAMPLE, 16'sh5555, 16'shAAAA, 6'h00, 16'sh7FFF, 1'b0,
			'0, '0));
		add_row(mk_item(cfir_pkg::OP_SAMPLE, 16'shAAAA, 16'sh5555, 6'h2A, 16'sh0001, 1'b0,
			'0, '0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				settle();
				write_tap_count(dir_rows[i].cfg);
			end else begin
				send_item(dir_rows[i].op, dir_rows[i].re, dir_rows[i].im, dir_rows[i].idx,
					dir_rows[i].val, dir_rows[i].has_want, dir_rows[i].want);
			end
		end

		// random phases: fresh tap count, a burst of tap loads, then mixed traffic
		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle_pct = 0;
			stall_pct = 0;
			settle();
			case (ph)
				0: taps = 64;
				1: taps = 1;
				2: taps = 127;
				3: taps = 0;
				4: taps = 17;
				5: taps = $urandom_range(126, 3);
				6: taps = 2;
				default: taps = 63;
			endcase
			write_tap_count(CNT_W'(taps));
			lim = active_taps();
			for (int n = 0; n < PHASE_LOADS + PHASE_ITEMS; n++) begin
				if (n % 16 == 0) begin
					// some stretches run with no idling at all
					if ($urandom_range(3) == 0 || ph % 4 == 0) begin
						send_idle_pct = 0;
						stall_pct = 0;
					end else if (ph % 4 == 1) begin
						send_idle_pct = 65;
						stall_pct = 0;
					end else if (ph % 4 == 2) begin
						send_idle_pct = 0;
						stall_pct = 65;
					end else begin
						send_idle_pct = 7;
						stall_pct = 7;
					end
				end
				if (n < PHASE_LOADS) begin
					send_random(cfir_pkg::OP_LOAD, IDX_W'($urandom_range(lim - 1)));
				end else begin
					o = ($urandom_range(99) < 18) ? cfir_pkg::OP_LOAD : cfir_pkg::OP_SAMPLE;
					send_random(o, IDX_W'($urandom_range(NT - 1)));
				end
			end
		end

		send_idle_pct = 0;
		stall_pct = 0;
		settle();
		if (pending_sums.size() != 0)
			report_mismatch("results left pending", longint'(pending_sums.size()), 0);

		$display("filtered %0d samples and applied %0d coefficient loads over %0d tap counts",
			n_samples, n_loads, n_settings);
		$display("compared %0d complex results, %0d mismatches", n_results, mismatches);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/cfir_pkg.sv
rtl/core/cfir_cell.sv
rtl/core/cfir_mac.sv
rtl/core/complex_fir_filter.sv
tb/tb.sv
